// File: rtl/core/uts_pkg.sv
package uts_pkg;

    // Input transaction: one byte of text with its line-end flag
    typedef struct packed {
        logic [7:0] data_byte;
        logic       line_end;
    } t_in;

    // Output transaction: running totals, low 32 bits of each counter
    typedef struct packed {
        logic [31:0] total_lines;
        logic [31:0] total_bytes;
        logic [31:0] total_words;
        logic [31:0] total_codepoints;
        logic [31:0] total_arabic;
    } t_out;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } t_state;

    localparam int unsigned CP_W = 21;

    // Result of one pass of the decode step
    typedef struct packed {
        logic             cp_valid;
        logic             arabic;
        logic             wr_en;
        logic [1:0]       fill_next;
        logic             replay;
        logic [1:0]       replay_len;
        logic [2:0][7:0]  replay_bytes;
    } t_step;

    // Byte classes
    localparam logic [7:0] MASK_2B = 8'hE0;
    localparam logic [7:0] LEAD_2B = 8'hC0;
    localparam logic [7:0] MASK_3B = 8'hF0;
    localparam logic [7:0] LEAD_3B = 8'hE0;
    localparam logic [7:0] MASK_4B = 8'hF8;
    localparam logic [7:0] LEAD_4B = 8'hF0;
    localparam logic [1:0] CONT_TAG = 2'b10;

    // Arabic ranges
    localparam logic [CP_W-1:0] AR0_LO = 21'h00600;
    localparam logic [CP_W-1:0] AR0_HI = 21'h006FF;
    localparam logic [CP_W-1:0] AR1_LO = 21'h00750;
    localparam logic [CP_W-1:0] AR1_HI = 21'h0077F;
    localparam logic [CP_W-1:0] AR2_LO = 21'h008A0;
    localparam logic [CP_W-1:0] AR2_HI = 21'h008FF;
    localparam logic [CP_W-1:0] AR3_LO = 21'h0FB50;
    localparam logic [CP_W-1:0] AR3_HI = 21'h0FDFF;
    localparam logic [CP_W-1:0] AR4_LO = 21'h0FE70;
    localparam logic [CP_W-1:0] AR4_HI = 21'h0FEFF;

    // Whitespace bytes
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_HT = 8'h09;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;
    localparam logic [7:0] CH_CR = 8'h0D;

    // Continuation count of a lead byte; 0 for anything that is not a lead
    function automatic logic [1:0] need_of(input logic [7:0] b);
        logic [1:0] n;
        n = 2'd0;
        if ((b & MASK_2B) == LEAD_2B) begin
            n = 2'd1;
        end else if ((b & MASK_3B) == LEAD_3B) begin
            n = 2'd2;
        end else if ((b & MASK_4B) == LEAD_4B) begin
            n = 2'd3;
        end
        return n;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SP) || (b == CH_HT) || (b == CH_LF) ||
               (b == CH_CR) || (b == CH_VT) || (b == CH_FF);
    endfunction

    function automatic logic in_arabic(input logic [CP_W-1:0] cp);
        return ((cp >= AR0_LO) && (cp <= AR0_HI)) ||
               ((cp >= AR1_LO) && (cp <= AR1_HI)) ||
               ((cp >= AR2_LO) && (cp <= AR2_HI)) ||
               ((cp >= AR3_LO) && (cp <= AR3_HI)) ||
               ((cp >= AR4_LO) && (cp <= AR4_HI));
    endfunction

endpackage

// File: rtl/core/uts_sat_counter.sv
module uts_sat_counter
    import uts_pkg::*;
#(
    parameter int unsigned W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_inc,
    output logic [W-1:0] o_count,
    output logic [W-1:0] o_next
);

    logic [W-1:0] r_count;
    logic [W-1:0] n_count;

    // Advance unless already at the top value
    always_comb begin
        n_count = r_count;
        if (i_inc && (r_count != {W{1'b1}})) begin
            n_count = r_count + W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count = r_count;
    assign o_next  = n_count;

endmodule

// File: rtl/core/uts_decode_step.sv
module uts_decode_step
    import uts_pkg::*;
(
    input  logic [3:0][7:0] i_window,
    input  logic [1:0]      i_fill,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    output t_step           o_step
);

    logic [1:0]      need;
    logic [3:0][7:0] cat;
    logic            ok;
    logic [CP_W-1:0] cp;

    // Window as it stands with the new byte placed at the fill position
    always_comb begin
        cat         = i_window;
        cat[i_fill] = i_byte;
        need        = need_of(i_window[0]);
    end

    // Check continuations and assemble the codepoint of a complete sequence
    always_comb begin
        ok = (cat[1][7:6] == CONT_TAG) &&
             ((need < 2'd2) || (cat[2][7:6] == CONT_TAG)) &&
             ((need < 2'd3) || (cat[3][7:6] == CONT_TAG));
        case (need)
            2'd1:    cp = {10'd0, cat[0][4:0], cat[1][5:0]};
            2'd2:    cp = {5'd0, cat[0][3:0], cat[1][5:0], cat[2][5:0]};
            2'd3:    cp = {cat[0][2:0], cat[1][5:0], cat[2][5:0], cat[3][5:0]};
            default: cp = '0;
        endcase
    end

    // Decide what this byte does to the window
    always_comb begin
        o_step              = '0;
        o_step.fill_next    = i_fill;
        o_step.replay_bytes = cat[3:1];
        o_step.replay_len   = need;
        if (i_fill == 2'd0) begin
            if (!i_byte[7]) begin
                o_step.cp_valid = 1'b1;
                o_step.arabic   = in_arabic({13'd0, i_byte});
            end else if ((need_of(i_byte) != 2'd0) && !i_last) begin
                o_step.wr_en     = 1'b1;
                o_step.fill_next = 2'd1;
            end
        end else begin
            o_step.wr_en = 1'b1;
            if (i_fill < need) begin
                // Still short of continuations: drop the partial sequence at line end
                o_step.fill_next = i_last ? 2'd0 : i_fill + 2'd1;
            end else begin
                o_step.fill_next = 2'd0;
                if (ok) begin
                    o_step.cp_valid = 1'b1;
                    o_step.arabic   = in_arabic(cp);
                end else begin
                    o_step.replay = 1'b1;
                end
            end
        end
    end

endmodule

// File: rtl/core/utf8_text_statistics.sv
// UTF-8 text statistics. Takes one byte per transaction, with line_end on the last byte of
// each line, and keeps saturating totals of lines, bytes, words, codepoints and codepoints in
// the Arabic ranges; at each line end one output transaction carries all five totals. An
// accepted byte goes into a three-entry byte queue and a shared decode step then handles one
// queued byte per cycle against a four-byte window; no new byte is accepted until the queue
// is empty. When a lead byte's continuations turn out bad, the bytes after the lead go back
// to the head of the queue and are decoded again, one per cycle; replays can nest. A line
// end result that finds the output register still occupied waits there until it is taken;
// the next byte is accepted while a finished result waits otherwise.
module utf8_text_statistics
    import uts_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_state          r_state;
    t_state          n_state;
    logic [2:0][7:0] r_q;
    logic [2:0][7:0] n_q;
    logic [1:0]      r_qcount;
    logic [1:0]      n_qcount;
    logic            r_last;
    logic [3:0][7:0] r_window;
    logic [1:0]      r_fill;
    logic            r_inside;
    logic            r_out_valid;
    t_out            r_out;

    logic  in_acc;
    logic  run;
    logic  out_free;
    logic  fin;
    logic  load_out;
    t_step step;

    logic [COUNT_WIDTH-1:0] cnt_lines, cnt_bytes, cnt_words, cnt_cp, cnt_ar;
    logic [COUNT_WIDTH-1:0] nxt_lines, nxt_bytes, nxt_words, nxt_cp, nxt_ar;

    // Shared decode step on the head of the queue
    uts_decode_step u_step (
        .i_window (r_window),
        .i_fill   (r_fill),
        .i_byte   (r_q[0]),
        .i_last   (r_last && (r_qcount == 2'd1)),
        .o_step   (step)
    );

    // Queue update: load, pop, or push replayed bytes to the front
    always_comb begin
        n_q      = r_q;
        n_qcount = r_qcount;
        if (in_acc) begin
            n_q[0]   = i_in_data.data_byte;
            n_qcount = 2'd1;
        end else if (run) begin
            if (step.replay) begin
                case (step.replay_len)
                    2'd1:    n_q = {r_q[2], r_q[1], step.replay_bytes[0]};
                    2'd2:    n_q = {r_q[1], step.replay_bytes[1], step.replay_bytes[0]};
                    default: n_q = step.replay_bytes;
                endcase
                n_qcount = 2'({1'b0, r_qcount} + {1'b0, step.replay_len} - 3'd1);
            end else begin
                n_q      = {r_q[2], r_q[2], r_q[1]};
                n_qcount = r_qcount - 2'd1;
            end
        end
    end

    assign run      = (r_state == S_RUN);
    assign out_free = !r_out_valid || i_out_ready;
    assign fin      = run && (n_qcount == 2'd0);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_RUN;
            end
            S_RUN: begin
                if (fin) n_state = (r_last && !out_free) ? S_HOLD : S_IDLE;
            end
            S_HOLD: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_ready = 1'b0;
        load_out   = 1'b0;
        unique case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_RUN:   load_out   = fin && r_last && out_free;
            S_HOLD:  load_out   = out_free;
            default: o_in_ready = 1'b0;
        endcase
    end

    assign in_acc = i_in_valid && o_in_ready;

    // Running totals
    uts_sat_counter #(.W(COUNT_WIDTH)) u_lines (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_inc (in_acc && i_in_data.line_end),
        .o_count (cnt_lines), .o_next (nxt_lines)
    );
    uts_sat_counter #(.W(COUNT_WIDTH)) u_bytes (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_inc (in_acc),
        .o_count (cnt_bytes), .o_next (nxt_bytes)
    );
    uts_sat_counter #(.W(COUNT_WIDTH)) u_words (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_inc (in_acc && !is_space(i_in_data.data_byte) && !r_inside),
        .o_count (cnt_words), .o_next (nxt_words)
    );
    uts_sat_counter #(.W(COUNT_WIDTH)) u_cp (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_inc (run && step.cp_valid),
        .o_count (cnt_cp), .o_next (nxt_cp)
    );
    uts_sat_counter #(.W(COUNT_WIDTH)) u_ar (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_inc (run && step.arabic),
        .o_count (cnt_ar), .o_next (nxt_ar)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_qcount    <= 2'd0;
            r_fill      <= 2'd0;
            r_inside    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_qcount <= n_qcount;
            if (run) r_fill <= step.fill_next;
            // Track word boundaries; words never span a line end
            if (in_acc) begin
                r_inside <= !is_space(i_in_data.data_byte) && !i_in_data.line_end;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_q <= n_q;
        if (in_acc) r_last <= i_in_data.line_end;
        if (run && step.wr_en) r_window[r_fill] <= r_q[0];
        if (load_out) begin
            r_out.total_lines      <= 32'(nxt_lines);
            r_out.total_bytes      <= 32'(nxt_bytes);
            r_out.total_words      <= 32'(nxt_words);
            r_out.total_codepoints <= 32'(nxt_cp);
            r_out.total_arabic     <= 32'(nxt_ar);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The window is empty once the last byte of a line has been decoded
    a_fill_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin && r_last) |=> (r_fill == 2'd0))
        else $error("window not empty after line end");

    // Replayed bytes plus what is left of the queue fit in the queue
    a_replay_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (run && step.replay) |->
            (({1'b0, r_qcount} + {1'b0, step.replay_len}) <= 3'd4))
        else $error("replay overflows byte queue");

    // Arabic codepoints are a subset of all codepoints
    a_ar_le_cp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_ar <= cnt_cp)
        else $error("arabic total exceeds codepoint total");

    // Bytes total never falls behind lines total
    a_lines_le_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_lines <= cnt_bytes)
        else $error("line total exceeds byte total");

    // Every word starts on a byte of its own
    a_words_le_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_words <= cnt_bytes)
        else $error("word total exceeds byte total");

endmodule
